[rtl/core/apt_pkg.sv]
// ----------------------------------------------------------------------------
// apt_pkg
// Shared widths, register map, reset values, controller commands and the
// configuration bundle of the altitude thrust controller.
// ----------------------------------------------------------------------------
package apt_pkg;

    localparam int DATA_W    = 32;
    localparam int TILT_W    = 18;
    localparam int STEP_W    = 17;
    localparam int GAIN_W    = 31;
    localparam int THR_W     = 29;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;

    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = 50;
    localparam int INTEG_W   = 20;
    localparam int DEN_W     = 17;
    localparam int QUOT_W    = 34;
    localparam int NUM_W     = 64;
    localparam int CNT_W     = 6;
    localparam int CLAMP_W   = QUOT_W + 1;

    localparam int S_TDATA_W = 200;
    localparam int M_TDATA_W = 32;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_POS_GAIN  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VEL_GAIN  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INT_GAIN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ASC   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_DESC  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MASS      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MIN_THR   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_MAX_THR   = 3'd7;

    // reset values, Q16.16
    localparam logic [GAIN_W-1:0] RST_GAIN     = 31'd0;
    localparam logic [GAIN_W-1:0] RST_MAX_RATE = 31'd6553600;
    localparam logic [GAIN_W-1:0] RST_MASS     = 31'd65536;
    localparam logic [THR_W-1:0]  RST_MIN_THR  = 29'd0;
    localparam logic [THR_W-1:0]  RST_MAX_THR  = 29'd6553600;

    // fixed constants, Q16.16 but for the divider's last step index
    localparam logic signed [DATA_W:0]    GRAVITY_Q     = 33'sd642908;
    localparam logic [DEN_W-1:0]          TILT_FLOOR_Q  = 17'd66;
    localparam logic signed [ACC_W-1:0]   INTEG_LIMIT_Q = 50'sd262144;
    localparam logic [CNT_W-1:0]          DIV_LAST      = 6'd33;

    // datapath operations
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_ERR1      = 4'd2;
    localparam logic [3:0] OP_ERR2      = 4'd3;
    localparam logic [3:0] OP_MUL_I     = 4'd4;
    localparam logic [3:0] OP_MUL_P     = 4'd5;
    localparam logic [3:0] OP_MUL_V     = 4'd6;
    localparam logic [3:0] OP_MUL_G     = 4'd7;
    localparam logic [3:0] OP_ACC_G     = 4'd8;
    localparam logic [3:0] OP_NUM       = 4'd9;
    localparam logic [3:0] OP_MUL_T     = 4'd10;
    localparam logic [3:0] OP_DIV_PREP  = 4'd11;
    localparam logic [3:0] OP_DIV_START = 4'd12;
    localparam logic [3:0] OP_DIV_STEP  = 4'd13;
    localparam logic [3:0] OP_CLAMP     = 4'd14;

    typedef struct packed {
        logic [3:0] op;
        logic       out_load;
    } apt_cmd_t;

    typedef struct packed {
        logic [GAIN_W-1:0] pos_gain;
        logic [GAIN_W-1:0] vel_gain;
        logic [GAIN_W-1:0] int_gain;
        logic [GAIN_W-1:0] max_asc;
        logic [GAIN_W-1:0] max_desc;
        logic [GAIN_W-1:0] mass;
        logic [THR_W-1:0]  min_thr;
        logic [THR_W-1:0]  max_thr;
    } apt_cfg_t;

endpackage

[rtl/core/altitude_pid_thrust_controller.sv]
// a result is registered on m_tdata once its item has passed the error, PID,
// thrust product, tilt correction (a 34-step radix-2 divider) and clamp states
// a new item is taken only in idle, once the last result is loaded for output
// aresetn (synchronous, active low) restores the register reset values,
// clears the altitude integrator and empties the output register
// ----------------------------------------------------------------------------
// altitude_pid_thrust_controller
// Vertical PID loop with clamped integrator that turns the commanded
// acceleration into a tilt-corrected collective thrust command.
// ----------------------------------------------------------------------------
module altitude_pid_thrust_controller import apt_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // target_position, target_velocity, measured_position, measured_velocity,
    // feedforward_accel, tilt_cosine, time_step, zero padding
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // thrust_command
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    apt_cfg_t                 cfg;
    apt_cmd_t                 cmd;
    logic signed [DATA_W-1:0] thrust;

    apt_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    apt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    apt_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .cfg               (cfg),
        .target_position   (s_tdata[31:0]),
        .target_velocity   (s_tdata[63:32]),
        .measured_position (s_tdata[95:64]),
        .measured_velocity (s_tdata[127:96]),
        .feedforward_accel (s_tdata[159:128]),
        .tilt_cosine       (s_tdata[177:160]),
        .time_step         (s_tdata[194:178]),
        .thrust_command    (thrust)
    );

    assign m_tdata = thrust;

endmodule

[rtl/core/apt_cfg.sv]
// ----------------------------------------------------------------------------
// apt_cfg
// APB register file holding gains, rate limits, mass and motor thrust limits.
// ----------------------------------------------------------------------------
module apt_cfg import apt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output apt_cfg_t          cfg
);

    apt_cfg_t             cfg_reg;
    apt_cfg_t             cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[APB_AW-1:2];
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_POS_GAIN: cfg_next.pos_gain = pwdata[GAIN_W-1:0];
                REG_VEL_GAIN: cfg_next.vel_gain = pwdata[GAIN_W-1:0];
                REG_INT_GAIN: cfg_next.int_gain = pwdata[GAIN_W-1:0];
                REG_MAX_ASC:  cfg_next.max_asc  = pwdata[GAIN_W-1:0];
                REG_MAX_DESC: cfg_next.max_desc = pwdata[GAIN_W-1:0];
                REG_MASS:     cfg_next.mass     = pwdata[GAIN_W-1:0];
                REG_MIN_THR:  cfg_next.min_thr  = pwdata[THR_W-1:0];
                REG_MAX_THR:  cfg_next.max_thr  = pwdata[THR_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pos_gain <= RST_GAIN;
            cfg_reg.vel_gain <= RST_GAIN;
            cfg_reg.int_gain <= RST_GAIN;
            cfg_reg.max_asc  <= RST_MAX_RATE;
            cfg_reg.max_desc <= RST_MAX_RATE;
            cfg_reg.mass     <= RST_MASS;
            cfg_reg.min_thr  <= RST_MIN_THR;
            cfg_reg.max_thr  <= RST_MAX_THR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            REG_POS_GAIN: prdata = {1'b0, cfg_reg.pos_gain};
            REG_VEL_GAIN: prdata = {1'b0, cfg_reg.vel_gain};
            REG_INT_GAIN: prdata = {1'b0, cfg_reg.int_gain};
            REG_MAX_ASC:  prdata = {1'b0, cfg_reg.max_asc};
            REG_MAX_DESC: prdata = {1'b0, cfg_reg.max_desc};
            REG_MASS:     prdata = {1'b0, cfg_reg.mass};
            REG_MIN_THR:  prdata = {3'b0, cfg_reg.min_thr};
            REG_MAX_THR:  prdata = {3'b0, cfg_reg.max_thr};
            default:      prdata = '0;
        endcase
    end

endmodule

[rtl/core/apt_ctrl.sv]
// ----------------------------------------------------------------------------
// apt_ctrl
// Sequencer: steps the datapath through error, PID, thrust product, the
// radix-2 divider and the final clamp, and owns the stream handshakes.
// ----------------------------------------------------------------------------
module apt_ctrl import apt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output apt_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_ERR1      = 4'd1;
    localparam logic [3:0] ST_ERR2      = 4'd2;
    localparam logic [3:0] ST_MUL_I     = 4'd3;
    localparam logic [3:0] ST_MUL_P     = 4'd4;
    localparam logic [3:0] ST_MUL_V     = 4'd5;
    localparam logic [3:0] ST_MUL_G     = 4'd6;
    localparam logic [3:0] ST_ACC_G     = 4'd7;
    localparam logic [3:0] ST_NUM       = 4'd8;
    localparam logic [3:0] ST_MUL_T     = 4'd9;
    localparam logic [3:0] ST_DIV_PREP  = 4'd10;
    localparam logic [3:0] ST_DIV_START = 4'd11;
    localparam logic [3:0] ST_DIV_STEP  = 4'd12;
    localparam logic [3:0] ST_CLAMP     = 4'd13;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_ERR1;
                end
            end
            ST_ERR1: begin
                cmd.op     = OP_ERR1;
                state_next = ST_ERR2;
            end
            ST_ERR2: begin
                cmd.op     = OP_ERR2;
                state_next = ST_MUL_I;
            end
            ST_MUL_I: begin
                cmd.op     = OP_MUL_I;
                state_next = ST_MUL_P;
            end
            ST_MUL_P: begin
                cmd.op     = OP_MUL_P;
                state_next = ST_MUL_V;
            end
            ST_MUL_V: begin
                cmd.op     = OP_MUL_V;
                state_next = ST_MUL_G;
            end
            ST_MUL_G: begin
                cmd.op     = OP_MUL_G;
                state_next = ST_ACC_G;
            end
            ST_ACC_G: begin
                cmd.op     = OP_ACC_G;
                state_next = ST_NUM;
            end
            ST_NUM: begin
                cmd.op     = OP_NUM;
                state_next = ST_MUL_T;
            end
            ST_MUL_T: begin
                cmd.op     = OP_MUL_T;
                state_next = ST_DIV_PREP;
            end
            ST_DIV_PREP: begin
                cmd.op     = OP_DIV_PREP;
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                cmd.op     = OP_DIV_START;
                cnt_next   = '0;
                state_next = ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
                cmd.op = OP_DIV_STEP;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_CLAMP;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_CLAMP: begin
                cmd.op = OP_CLAMP;
                // hold here while the previous result is still waiting
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

[rtl/core/apt_dp.sv]
// ----------------------------------------------------------------------------
// apt_dp
// Datapath: error terms, shared 33x33 multiplier, PID accumulator, altitude
// integrator, restoring divider and the final thrust clamp.
// ----------------------------------------------------------------------------
module apt_dp import apt_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  apt_cmd_t                 cmd,
    input  apt_cfg_t                 cfg,
    input  logic signed [DATA_W-1:0] target_position,
    input  logic signed [DATA_W-1:0] target_velocity,
    input  logic signed [DATA_W-1:0] measured_position,
    input  logic signed [DATA_W-1:0] measured_velocity,
    input  logic signed [DATA_W-1:0] feedforward_accel,
    input  logic signed [TILT_W-1:0] tilt_cosine,
    input  logic        [STEP_W-1:0] time_step,
    output logic signed [DATA_W-1:0] thrust_command
);

    localparam logic signed [ACC_W-1:0]   ACC_MAX   = 50'sd2147483647;
    localparam logic signed [ACC_W-1:0]   ACC_MIN   = -50'sd2147483648;
    localparam logic signed [CLAMP_W-1:0] CL_MAX    = 35'sd2147483647;
    localparam logic signed [CLAMP_W-1:0] CL_MIN    = -35'sd2147483648;
    localparam logic signed [PROD_W-1:0]  RND_HALF  = 66'sd32768;

    // Q32 product to Q16.16, round half up
    function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + RND_HALF;
        return s[PROD_W-1:16];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1]) begin
            r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    logic signed [DATA_W-1:0]  tp_reg, tv_reg, mp_reg, mv_reg, ff_reg;
    logic signed [TILT_W-1:0]  tc_reg;
    logic        [STEP_W-1:0]  dt_reg;
    logic signed [DATA_W-1:0]  vcmd_reg, perr_reg, verr_reg;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [DATA_W:0]    num_reg;
    logic        [NUM_W-1:0]   n_reg;
    logic        [DEN_W-1:0]   den_reg;
    logic                      neg_reg, ovf_reg;
    logic        [DEN_W-1:0]   rem_reg;
    logic        [QUOT_W-1:0]  q_reg;
    logic signed [DATA_W-1:0]  out_reg;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [ACC_W-1:0]   prod_rnd;
    logic signed [DATA_W:0]    lim_hi, lim_lo, tv_ext, vmin, vcmd;
    logic signed [ACC_W-1:0]   isum;
    logic signed [DATA_W-1:0]  accel;
    logic        [DEN_W-1:0]   den;
    logic        [NUM_W-1:0]   n_base, n_inc;
    logic        [DEN_W:0]     shifted, sdiff;
    logic                      ge;
    logic        [QUOT_W-1:0]  qv;
    logic signed [CLAMP_W-1:0] t_val, hi5, lo5, tmin, tcl;

    assign thrust_command = out_reg;
    assign prod_rnd       = rnd16(prod_reg);

    // velocity target limit, used by the velocity error
    always_comb begin
        lim_hi = {2'b0, cfg.max_desc};
        lim_lo = -$signed({2'b0, cfg.max_asc});
        tv_ext = {tv_reg[DATA_W-1], tv_reg};
        vmin   = (tv_ext < lim_hi) ? tv_ext : lim_hi;
        vcmd   = (vmin > lim_lo) ? vmin : lim_lo;
    end

    // shared multiplier operand select
    always_comb begin
        case (cmd.op)
            OP_MUL_I: begin
                mul_a = {perr_reg[DATA_W-1], perr_reg};
                mul_b = {{(MUL_W-STEP_W){1'b0}}, dt_reg};
            end
            OP_MUL_P: begin
                mul_a = {2'b0, cfg.pos_gain};
                mul_b = {perr_reg[DATA_W-1], perr_reg};
            end
            OP_MUL_V: begin
                mul_a = {2'b0, cfg.vel_gain};
                mul_b = {verr_reg[DATA_W-1], verr_reg};
            end
            OP_MUL_G: begin
                mul_a = {2'b0, cfg.int_gain};
                mul_b = {{(MUL_W-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg};
            end
            OP_MUL_T: begin
                mul_a = {2'b0, cfg.mass};
                mul_b = num_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // integrator saturates at plus or minus 4.0
    always_comb begin
        isum = {{(ACC_W-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg} + prod_rnd;
        if (isum > INTEG_LIMIT_Q) begin
            integ_next = INTEG_LIMIT_Q[INTEG_W-1:0];
        end else if (isum < -INTEG_LIMIT_Q) begin
            integ_next = -INTEG_LIMIT_Q[INTEG_W-1:0];
        end else begin
            integ_next = isum[INTEG_W-1:0];
        end
    end

    always_comb begin
        if (acc_reg > ACC_MAX) begin
            accel = ACC_MAX[DATA_W-1:0];
        end else if (acc_reg < ACC_MIN) begin
            accel = ACC_MIN[DATA_W-1:0];
        end else begin
            accel = acc_reg[DATA_W-1:0];
        end
    end

    // divisor floor and rounded dividend magnitude
    always_comb begin
        if (tc_reg > $signed({1'b0, TILT_FLOOR_Q})) begin
            den = tc_reg[DEN_W-1:0];
        end else begin
            den = TILT_FLOOR_Q;
        end
        n_base = prod_reg[PROD_W-1] ? ~prod_reg[NUM_W-1:0] : prod_reg[NUM_W-1:0];
        n_inc  = {{(NUM_W-DEN_W+1){1'b0}}, den[DEN_W-1:1]}
               + {{(NUM_W-1){1'b0}}, prod_reg[PROD_W-1]};
    end

    // one restoring divide step
    always_comb begin
        shifted = {rem_reg, q_reg[QUOT_W-1]};
        sdiff   = shifted - {1'b0, den_reg};
        ge      = (shifted >= {1'b0, den_reg});
    end

    // signed quotient and motor thrust limits
    always_comb begin
        qv    = ovf_reg ? {QUOT_W{1'b1}} : q_reg;
        t_val = neg_reg ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
        hi5   = $signed({{(CLAMP_W-THR_W-2){1'b0}}, cfg.max_thr, 2'b0})
              + $signed({{(CLAMP_W-THR_W){1'b0}}, cfg.max_thr});
        lo5   = $signed({{(CLAMP_W-THR_W-2){1'b0}}, cfg.min_thr, 2'b0})
              + $signed({{(CLAMP_W-THR_W){1'b0}}, cfg.min_thr});
        tmin  = (t_val < hi5) ? t_val : hi5;
        tcl   = (tmin > lo5) ? tmin : lo5;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
        end else if (cmd.op == OP_MUL_P) begin
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                tp_reg <= target_position;
                tv_reg <= target_velocity;
                mp_reg <= measured_position;
                mv_reg <= measured_velocity;
                ff_reg <= feedforward_accel;
                tc_reg <= tilt_cosine;
                dt_reg <= time_step;
            end
            OP_ERR1: begin
                vcmd_reg <= vcmd[DATA_W-1:0];
                perr_reg <= sat33({tp_reg[DATA_W-1], tp_reg} - {mp_reg[DATA_W-1], mp_reg});
            end
            OP_ERR2: begin
                verr_reg <= sat33({vcmd_reg[DATA_W-1], vcmd_reg}
                                  - {mv_reg[DATA_W-1], mv_reg});
            end
            OP_MUL_I, OP_MUL_P: begin
                prod_reg <= mul_a * mul_b;
            end
            OP_MUL_V: begin
                prod_reg <= mul_a * mul_b;
                acc_reg  <= {{(ACC_W-DATA_W){ff_reg[DATA_W-1]}}, ff_reg} + prod_rnd;
            end
            OP_MUL_G: begin
                prod_reg <= mul_a * mul_b;
                acc_reg  <= acc_reg + prod_rnd;
            end
            OP_ACC_G: begin
                acc_reg <= acc_reg + prod_rnd;
            end
            OP_NUM: begin
                num_reg <= GRAVITY_Q - {accel[DATA_W-1], accel};
            end
            OP_MUL_T: begin
                prod_reg <= mul_a * mul_b;
            end
            OP_DIV_PREP: begin
                neg_reg <= prod_reg[PROD_W-1];
                den_reg <= den;
                n_reg   <= n_base + n_inc;
            end
            OP_DIV_START: begin
                ovf_reg <= (n_reg[NUM_W-1:QUOT_W]
                            >= {{(NUM_W-QUOT_W-DEN_W){1'b0}}, den_reg});
                rem_reg <= n_reg[QUOT_W+DEN_W-1:QUOT_W];
                q_reg   <= n_reg[QUOT_W-1:0];
            end
            OP_DIV_STEP: begin
                rem_reg <= ge ? sdiff[DEN_W-1:0] : shifted[DEN_W-1:0];
                q_reg   <= {q_reg[QUOT_W-2:0], ge};
            end
            OP_CLAMP: begin
                if (cmd.out_load) begin
                    if (tcl > CL_MAX) begin
                        out_reg <= CL_MAX[DATA_W-1:0];
                    end else if (tcl < CL_MIN) begin
                        out_reg <= CL_MIN[DATA_W-1:0];
                    end else begin
                        out_reg <= tcl[DATA_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[tb/altitude_pid_thrust_controller_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// altitude_pid_thrust_controller_tb
// Self-checking bench for the altitude thrust controller. Items stream in with
// random gaps and output stalls, each accepted item is run through a
// cycle-free model of the PID loop, integrator and thrust clamp, and every
// thrust command is compared in order. Register settings change between
// drained phases and are read back.
// ----------------------------------------------------------------------------
module altitude_pid_thrust_controller_tb;
    import apt_pkg::*;

    localparam int     NUM_REGS = 8;
    localparam int     ONE_Q    = 65536;
    localparam int     I32_MIN  = int'(32'h8000_0000);
    localparam int     I32_MAX  = int'(32'h7FFF_FFFF);
    localparam longint Q32_MIN  = -64'sd2147483648;
    localparam longint Q32_MAX  = 64'sd2147483647;

    // first member sits in the top bits, so target_position lands at bit 0
    typedef struct packed {
        logic [4:0]         pad;
        logic [16:0]        dt;
        logic signed [17:0] tilt;
        logic signed [31:0] ff;
        logic signed [31:0] mv;
        logic signed [31:0] mp;
        logic signed [31:0] tv;
        logic signed [31:0] tp;
    } alt_item_t;

    class thrust_checker;
        logic [31:0] reg_file [NUM_REGS];
        longint      integ;
        logic [31:0] thrust_expected [$];
        int          mismatches;
        int          items_seen;
        int          results_seen;

        function new();
            reg_file = '{32'(RST_GAIN), 32'(RST_GAIN), 32'(RST_GAIN), 32'(RST_MAX_RATE),
                         32'(RST_MAX_RATE), 32'(RST_MASS), 32'(RST_MIN_THR),
                         32'(RST_MAX_THR)};
            integ = 0;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
            if (idx == REG_MIN_THR || idx == REG_MAX_THR) begin
                reg_file[idx] = value & 32'h1FFF_FFFF;
            end else begin
                reg_file[idx] = value & 32'h7FFF_FFFF;
            end
        endfunction

        function longint clip(longint x, longint lo, longint hi);
            longint m;
            m = (x < hi) ? x : hi;
            return (m > lo) ? m : lo;
        endfunction

        // Q16.16 product, round half up
        function longint mul_q(longint a, longint b);
            return (a * b + 64'sd32768) >>> 16;
        endfunction

        function logic [31:0] predict_thrust(alt_item_t it);
            longint tp, tv, mp, mv, ff, tc, dt;
            longint vcmd, perr, verr, accel, prod, mag, q, den, floor_q, thrust;
            tp = longint'(it.tp);
            tv = longint'(it.tv);
            mp = longint'(it.mp);
            mv = longint'(it.mv);
            ff = longint'(it.ff);
            tc = longint'(it.tilt);
            dt = longint'(it.dt);
            floor_q = longint'(TILT_FLOOR_Q);

            vcmd = clip(tv, -longint'(reg_file[REG_MAX_ASC]), longint'(reg_file[REG_MAX_DESC]));
            perr = clip(tp - mp, Q32_MIN, Q32_MAX);
            verr = clip(vcmd - mv, Q32_MIN, Q32_MAX);
            integ = clip(integ + mul_q(perr, dt),
                         -longint'(INTEG_LIMIT_Q), longint'(INTEG_LIMIT_Q));
            accel = mul_q(longint'(reg_file[REG_POS_GAIN]), perr)
                  + mul_q(longint'(reg_file[REG_VEL_GAIN]), verr)
                  + mul_q(longint'(reg_file[REG_INT_GAIN]), integ) + ff;
            accel = clip(accel, Q32_MIN, Q32_MAX);

            // tilt correction, round half away from zero
            prod = longint'(reg_file[REG_MASS]) * (longint'(GRAVITY_Q) - accel);
            den = (tc > floor_q) ? tc : floor_q;
            mag = (prod < 0) ? -prod : prod;
            q = (mag + den / 2) / den;
            thrust = (prod < 0) ? -q : q;

            thrust = clip(thrust, 5 * longint'(reg_file[REG_MIN_THR]),
                          5 * longint'(reg_file[REG_MAX_THR]));
            thrust = clip(thrust, Q32_MIN, Q32_MAX);
            return thrust[31:0];
        endfunction

        function void flag(string what, logic [31:0] exp_v, logic [31:0] got_v);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t mismatch on %s: expected %h (%0d), got %h (%0d)", $time, what,
                         exp_v, $signed(exp_v), got_v, $signed(got_v));
            end
        endfunction

        function void note_item(alt_item_t it);
            items_seen++;
            thrust_expected.push_back(predict_thrust(it));
        endfunction

        function void check_thrust(logic [31:0] got);
            logic [31:0] want;
            results_seen++;
            if (thrust_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t thrust result %h with no item outstanding", $time, got);
                end
            end else begin
                want = thrust_expected.pop_front();
                if (got !== want) begin
                    flag($sformatf("thrust_command of result %0d", results_seen), want, got);
                end
            end
        endfunction

        function int pending();
            return thrust_expected.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    thrust_checker sb = new();
    int            tready_hold = 0;
    bit            quiet = 1'b0;
    bit            sender_idles = 1'b1;
    int            settings_used = 0;

    altitude_pid_thrust_controller uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("altitude_pid_thrust_controller_tb failed");
        $finish;
    end

    // results are checked before the item accepted at the same edge is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_thrust(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                sb.note_item(alt_item_t'(s_tdata));
            end
        end
    end

    // output side: random stalls, one long hold-off on request
    initial begin
        int n;
        forever begin
            if (tready_hold > 0) begin
                n = tready_hold;
                tready_hold = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic check_regs();
        logic [REG_IDX_W-1:0] idx;
        for (int i = 0; i < NUM_REGS; i++) begin
            idx = REG_IDX_W'(i);
            paddr   <= {idx, 2'b00};
            pwrite  <= 1'b0;
            psel    <= 1'b1;
            penable <= 1'b0;
            @(posedge aclk);
            penable <= 1'b1;
            @(negedge aclk);
            if (prdata !== sb.reg_file[idx]) begin
                sb.flag($sformatf("readback of register %0d", i), sb.reg_file[idx], prdata);
            end
            @(posedge aclk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic set_regs(input logic [31:0] pg, vg, ig, asc, desc, mass, tmin, tmax);
        apb_write(REG_POS_GAIN, pg);
        apb_write(REG_VEL_GAIN, vg);
        apb_write(REG_INT_GAIN, ig);
        apb_write(REG_MAX_ASC, asc);
        apb_write(REG_MAX_DESC, desc);
        apb_write(REG_MASS, mass);
        apb_write(REG_MIN_THR, tmin);
        apb_write(REG_MAX_THR, tmax);
        settings_used++;
        check_regs();
    endtask

    // realistic values half the time, full-width bits otherwise
    task automatic set_random_regs();
        logic [31:0] v [NUM_REGS];
        for (int i = 0; i < NUM_REGS; i++) begin
            v[i] = $urandom;
        end
        if ($urandom_range(0, 1) == 0) begin
            v[0] = $urandom_range(0, 10 * ONE_Q);
            v[1] = $urandom_range(0, 10 * ONE_Q);
            v[2] = $urandom_range(0, 5 * ONE_Q);
            v[3] = $urandom_range(0, 20 * ONE_Q);
            v[4] = $urandom_range(0, 20 * ONE_Q);
            v[5] = $urandom_range(ONE_Q / 5, 5 * ONE_Q);
            v[6] = $urandom_range(0, 2 * ONE_Q);
            v[7] = $urandom_range(2 * ONE_Q, 30 * ONE_Q);
        end
        set_regs(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    endtask

    task automatic send_item(input alt_item_t it);
        if (sender_idles && !quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tdata  <= it;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering items and wait for every thrust result
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
        repeat (4) @(posedge aclk);
    endtask

    function automatic alt_item_t make_item(int tp, int tv, int mp, int mv, int ff,
                                            int tilt, int dt);
        alt_item_t it;
        it      = '0;
        it.tp   = tp;
        it.tv   = tv;
        it.mp   = mp;
        it.mv   = mv;
        it.ff   = ff;
        it.tilt = tilt[17:0];
        it.dt   = dt[16:0];
        return it;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0: return I32_MIN;
            1: return I32_MAX;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    function automatic alt_item_t rand_item();
        alt_item_t it;
        int        k;
        int        base;
        it = '0;
        k = $urandom_range(0, 99);
        if (k < 60) begin
            // flight-like: +-50 m altitude, errors of a few meters
            base  = int'($urandom_range(0, 100 * ONE_Q)) - 50 * ONE_Q;
            it.tp = base;
            it.mp = base + int'($urandom_range(0, 10 * ONE_Q)) - 5 * ONE_Q;
            it.tv = int'($urandom_range(0, 40 * ONE_Q)) - 20 * ONE_Q;
            it.mv = int'($urandom_range(0, 40 * ONE_Q)) - 20 * ONE_Q;
            it.ff = int'($urandom_range(0, 20 * ONE_Q)) - 10 * ONE_Q;
            it.tilt = 18'($urandom_range(ONE_Q / 2, ONE_Q));
            it.dt = 17'($urandom_range(66, 3277));
        end else if (k < 85) begin
            it.tp = $urandom;
            it.tv = $urandom;
            it.mp = $urandom;
            it.mv = $urandom;
            it.ff = $urandom;
            it.tilt = 18'($urandom);
            it.dt = 17'($urandom);
        end else begin
            it.tp = pick_extreme();
            it.tv = pick_extreme();
            it.mp = pick_extreme();
            it.mv = pick_extreme();
            it.ff = pick_extreme();
            case ($urandom_range(0, 6))
                0: it.tilt = 18'(-ONE_Q);
                1: it.tilt = '0;
                2: it.tilt = 18'sd66;
                3: it.tilt = 18'sd67;
                4: it.tilt = 18'(ONE_Q);
                5: it.tilt = 18'h1FFFF;
                default: it.tilt = 18'h20000;
            endcase
            case ($urandom_range(0, 3))
                0: it.dt = '0;
                1: it.dt = 17'd1;
                2: it.dt = 17'(ONE_Q);
                default: it.dt = 17'h1FFFF;
            endcase
        end
        return it;
    endfunction

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++) begin
            send_item(rand_item());
        end
    endtask

    task automatic send_directed();
        // level hover, floored tilt, upside-down tilt, tilt right at the floor
        send_item(make_item(0, 0, 0, 0, 0, ONE_Q, 656));
        send_item(make_item(0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(0, 0, 0, 0, 0, -ONE_Q, 656));
        send_item(make_item(0, 0, 0, 0, 0, 1, 656));
        send_item(make_item(0, 0, 0, 0, 0, 66, 656));
        send_item(make_item(0, 0, 0, 0, 0, 67, 656));
        // velocity target beyond the descent and ascent limits
        send_item(make_item(0, I32_MAX, 0, 0, 0, ONE_Q, 656));
        send_item(make_item(0, I32_MIN, 0, 0, 0, ONE_Q, 656));
        // position error saturates, integrator runs into both limits
        send_item(make_item(I32_MAX, 0, I32_MIN, 0, 0, ONE_Q, ONE_Q));
        send_item(make_item(I32_MAX, 0, I32_MIN, 0, 0, ONE_Q, ONE_Q));
        send_item(make_item(I32_MIN, 0, I32_MAX, 0, 0, ONE_Q, ONE_Q));
        send_item(make_item(I32_MIN, 0, I32_MAX, 0, 0, ONE_Q, ONE_Q));
        // velocity error saturation both ways
        send_item(make_item(0, I32_MAX, 0, I32_MIN, 0, ONE_Q, 0));
        send_item(make_item(0, I32_MIN, 0, I32_MAX, 0, ONE_Q, 0));
        // acceleration saturation, thrust driven to both clamps
        send_item(make_item(0, 0, 0, 0, I32_MAX, ONE_Q, 0));
        send_item(make_item(0, 0, 0, 0, I32_MIN, ONE_Q, 0));
        // out-of-range bit patterns of tilt and time step
        send_item(make_item(ONE_Q, 0, 0, 0, 0, 18'h1FFFF, 17'h1FFFF));
        send_item(make_item(-ONE_Q, 0, 0, 0, 0, 18'h20000, 17'h1FFFF));
        // rounding ties in the integrator product
        send_item(make_item(1, 0, 0, 0, 0, ONE_Q, 32768));
        send_item(make_item(-1, 0, 0, 0, 0, ONE_Q, 32768));
        send_item(make_item(-3, 0, 0, 0, 0, ONE_Q, 32768));
        send_item(make_item(0, 0, 0, 0, 0, ONE_Q, ONE_Q));
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values
        check_regs();
        settings_used++;
        send_random(30);
        drain();

        // typical tuning for the directed items
        set_regs(32'd131072, 32'd98304, 32'd32768, 32'd196608, 32'd65536,
                 32'd98304, 32'd32768, 32'd524288);
        send_directed();
        send_random(60);

        // output held off long enough to back up the input
        drain();
        tready_hold = 400;
        send_random(40);
        drain();

        // every register at its top value, upper bits of the write dropped
        set_regs('1, '1, '1, '1, '1, '1, '1, '1);
        send_random(40);
        drain();

        set_regs('0, '0, '0, '0, '0, '0, '0, '0);
        send_random(25);
        drain();

        // minimum thrust above maximum thrust
        set_regs(32'd65536, 32'd65536, 32'd16384, 32'd655360, 32'd655360,
                 32'd131072, 32'd3276800, 32'd655360);
        send_random(30);

        for (int p = 0; p < 4; p++) begin
            drain();
            set_random_regs();
            sender_idles = (p != 2);
            send_random(40);
        end
        sender_idles = 1'b1;

        // back-to-back finish with no idling on either side
        drain();
        set_random_regs();
        quiet = 1'b1;
        send_random(50);
        drain();
        repeat (60) @(posedge aclk);

        $display("covered %0d items and %0d thrust results under %0d register settings,",
                 sb.items_seen, sb.results_seen, settings_used);
        $display("including saturation, tilt floor, inverted limits and a stalled output; %0d errors",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("altitude_pid_thrust_controller_tb passed");
        end else begin
            $display("altitude_pid_thrust_controller_tb failed");
        end
        $finish;
    end

endmodule

[altitude_pid_thrust_controller.f]
rtl/core/apt_pkg.sv
rtl/core/apt_cfg.sv
rtl/core/apt_ctrl.sv
rtl/core/apt_dp.sv
rtl/core/altitude_pid_thrust_controller.sv
tb/altitude_pid_thrust_controller_tb.sv
